FILE: rtl/core/acsf_pkg.sv
// ----------------------------------------------------------------------------
// acsf_pkg
// Shared constants, a type and a helper function of the adaptive smoothing filter.
// ----------------------------------------------------------------------------
package acsf_pkg;

   localparam int unsigned CHANNELS   = 12;
   localparam int unsigned CHAN_W     = 4;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned DIFF_W     = SAMPLE_W + 1;
   localparam int unsigned HIST_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CHAN_EXT_W = CHAN_W + HIST_AW;
   localparam int unsigned THRESH_W   = 3;
   localparam int unsigned LZ_BASE    = 24;
   localparam int unsigned SMALL_W    = 32 - LZ_BASE;
   localparam int unsigned LZ_W       = $clog2(SMALL_W + 1);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 16'hffc0;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_OFF    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_OFFSET = 2'd1;

   typedef struct packed {
      logic                en;
      logic [HIST_AW-1:0]  addr;
      logic [SAMPLE_W-1:0] data;
   } hist_wr_type;

   function automatic logic [LZ_W-1:0] lead_zeros(input logic [SMALL_W-1:0] v);
      logic [LZ_W-1:0] n;
      logic            hit;
      n   = '0;
      hit = 1'b0;
      for (int i = SMALL_W - 1; i >= 0; i--) begin
         if (!hit && !v[i]) begin
            n = n + LZ_W'(1);
         end else begin
            hit = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

FILE: rtl/core/acsf_history.sv
// ----------------------------------------------------------------------------
// acsf_history
// Per-channel stored value, cleared at reset, one read and one write port.
// ----------------------------------------------------------------------------
module acsf_history (
   input  logic                             clock,
   input  logic                             reset,
   input  acsf_pkg::hist_wr_type            wr,
   input  logic [acsf_pkg::HIST_AW-1:0]     rd_addr,
   output logic [acsf_pkg::SAMPLE_W-1:0]    rd_data
);

   logic [acsf_pkg::SAMPLE_W-1:0] hist_ff [acsf_pkg::CHANNELS];
   logic                          rd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(acsf_pkg::CHANNELS); i++) begin
            hist_ff[i] <= '0;
         end
      end else if (wr.en) begin
         hist_ff[wr.addr] <= wr.data;
      end
   end

   assign rd_valid = (acsf_pkg::HIST_AW + 1)'(rd_addr) <
                     (acsf_pkg::HIST_AW + 1)'(acsf_pkg::CHANNELS);
   assign rd_data  = rd_valid ? hist_ff[rd_addr] : '0;

endmodule

FILE: rtl/core/acsf_step.sv
// ----------------------------------------------------------------------------
// acsf_step
// Update of one stored value: masked difference, small-step damping, bypass.
// ----------------------------------------------------------------------------
module acsf_step (
   input  logic [acsf_pkg::SAMPLE_W-1:0] old_value,
   input  logic [acsf_pkg::SAMPLE_W-1:0] raw_sample,
   input  logic                          smoothing_off,
   input  logic [acsf_pkg::THRESH_W-1:0] threshold_offset,
   output logic [acsf_pkg::SAMPLE_W-1:0] new_value
);

   logic [acsf_pkg::SAMPLE_W-1:0]    masked;
   logic [acsf_pkg::DIFF_W-1:0]      diff;
   logic [acsf_pkg::DIFF_W-1:0]      mag;
   logic                             small_step;
   logic [acsf_pkg::LZ_W-1:0]        lz;
   logic [acsf_pkg::LZ_W-1:0]        thresh;
   logic                             damp;
   logic [acsf_pkg::LZ_W-1:0]        sh;
   logic signed [acsf_pkg::SMALL_W:0] d_small;
   logic signed [acsf_pkg::SMALL_W:0] d_shifted;
   logic [acsf_pkg::SAMPLE_W-1:0]    damped;

   assign masked     = raw_sample & acsf_pkg::SAMPLE_MASK;
   assign diff       = {1'b0, masked} - {1'b0, old_value};
   assign mag        = diff[acsf_pkg::DIFF_W-1] ? (acsf_pkg::DIFF_W'(0) - diff) : diff;
   assign small_step = (mag[acsf_pkg::DIFF_W-1:acsf_pkg::SMALL_W] == '0);
   assign lz         = acsf_pkg::lead_zeros(mag[acsf_pkg::SMALL_W-1:0]);
   assign thresh     = acsf_pkg::LZ_W'(threshold_offset);
   assign damp       = small_step && (lz > thresh);
   assign sh         = lz - thresh;
   assign d_small    = signed'(diff[acsf_pkg::SMALL_W:0]);
   assign d_shifted  = d_small >>> sh;
   assign damped     = old_value + acsf_pkg::SAMPLE_W'(d_shifted);

   always_comb begin
      if (smoothing_off || !damp) begin
         new_value = masked;
      end else begin
         new_value = damped;
      end
   end

endmodule

FILE: rtl/core/adaptive_cv_smoothing_filter.sv
// An accepted word passes the input and result registers. Throughput: one
// word per cycle while rsp_ready is high; the stored value is read and
// written in the same cycle, so consecutive words on one channel follow
// back to back. Reset: synchronous; clears all stored values, the pipeline
// and both configuration registers (smoothing on, threshold offset 0).
// ----------------------------------------------------------------------------
// adaptive_cv_smoothing_filter
// Top level: input register, per-channel update, result register, CSR port.
// ----------------------------------------------------------------------------
module adaptive_cv_smoothing_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [acsf_pkg::CHAN_W-1:0]     req_channel,
   input  logic [acsf_pkg::SAMPLE_W-1:0]   req_raw_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [acsf_pkg::CHAN_W-1:0]     rsp_channel_out,
   output logic [acsf_pkg::SAMPLE_W-1:0]   rsp_filtered_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [acsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [acsf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                            s1_valid_ff, s1_valid_in;
   logic [acsf_pkg::CHAN_W-1:0]     s1_channel_ff;
   logic [acsf_pkg::SAMPLE_W-1:0]   s1_sample_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [acsf_pkg::CHAN_W-1:0]     rsp_channel_ff;
   logic [acsf_pkg::SAMPLE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                            smoothing_off_ff, smoothing_off_in;
   logic [acsf_pkg::THRESH_W-1:0]   threshold_offset_ff, threshold_offset_in;

   logic                              advance;
   logic                              take;
   logic [acsf_pkg::CHAN_EXT_W-1:0]   ch_ext;
   logic                              in_range;
   logic [acsf_pkg::SAMPLE_W-1:0]     hist_rd_data;
   logic [acsf_pkg::SAMPLE_W-1:0]     new_value;
   acsf_pkg::hist_wr_type             hist_wr;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign ch_ext   = acsf_pkg::CHAN_EXT_W'(s1_channel_ff);
   assign in_range = ch_ext < acsf_pkg::CHAN_EXT_W'(acsf_pkg::CHANNELS);

   acsf_history u_history (
      .clock   (clock),
      .reset   (reset),
      .wr      (hist_wr),
      .rd_addr (ch_ext[acsf_pkg::HIST_AW-1:0]),
      .rd_data (hist_rd_data)
   );

   acsf_step u_step (
      .old_value        (hist_rd_data),
      .raw_sample       (s1_sample_ff),
      .smoothing_off    (smoothing_off_ff),
      .threshold_offset (threshold_offset_ff),
      .new_value        (new_value)
   );

   always_comb begin
      hist_wr.en   = advance && in_range;
      hist_wr.addr = ch_ext[acsf_pkg::HIST_AW-1:0];
      hist_wr.data = new_value;
   end

   always_comb begin
      s1_valid_in  = take || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
      rsp_value_in = in_range ? new_value : '0;
   end

   always_comb begin
      smoothing_off_in    = smoothing_off_ff;
      threshold_offset_in = threshold_offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            acsf_pkg::CSR_SMOOTHING_OFF: begin
               smoothing_off_in = csr_wdata[0];
            end
            acsf_pkg::CSR_THRESHOLD_OFFSET: begin
               threshold_offset_in = csr_wdata[acsf_pkg::THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         smoothing_off_ff    <= 1'b0;
         threshold_offset_ff <= '0;
      end else begin
         s1_valid_ff         <= s1_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         smoothing_off_ff    <= smoothing_off_in;
         threshold_offset_ff <= threshold_offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_raw_sample;
      end
      if (advance) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_value_ff   <= rsp_value_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel_out    = rsp_channel_ff;
   assign rsp_filtered_value = rsp_value_ff;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_range) |=> (rsp_valid && rsp_filtered_value == '0))
      else $error("out-of-range channel produced nonzero value");

   a_hist_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      hist_wr.en |=> (rsp_valid && rsp_filtered_value == $past(hist_wr.data)))
      else $error("stored value differs from response word");

   a_bypass: assert property (@(posedge clock) disable iff (reset)
      (advance && in_range && smoothing_off_ff) |=>
         (rsp_filtered_value == $past(s1_sample_ff & acsf_pkg::SAMPLE_MASK)))
      else $error("bypass value is not the masked sample");

endmodule
